[rtl/mmas_pkg.sv]
// Shared types and constants for the masked moving average scan filter.
package mmas_pkg;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;

	typedef struct packed {
		logic avg;
		logic edge_pt;
		logic last;
	} mmas_ctl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} mmas_bstate_t;

endpackage

[rtl/mmas_front.sv]
// Front end: point window, running valid sums and per-result task sequencing.
module mmas_front #(
	parameter int HALF_WINDOW = 4,
	parameter int COORD_WIDTH = 16,
	localparam int WIN = 2 * HALF_WINDOW + 1,
	localparam int CNT_W = $clog2(WIN + 1),
	localparam int SUM_W = COORD_WIDTH + $clog2(WIN)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] x_mm,
	input  logic signed [COORD_WIDTH-1:0] y_mm,
	input  logic                          point_valid,
	input  logic                          end_of_scan,
	input  logic                          q_full,
	output logic                          q_push,
	output mmas_pkg::mmas_ctl_t           q_ctl,
	output logic signed [COORD_WIDTH-1:0] q_x,
	output logic signed [COORD_WIDTH-1:0] q_y,
	output logic signed [SUM_W-1:0]       q_sx,
	output logic signed [SUM_W-1:0]       q_sy,
	output logic [CNT_W-1:0]              q_cnt
);

	localparam int PS_W = $clog2(2 * HALF_WINDOW + 1);
	localparam int K_W = $clog2(HALF_WINDOW + 1);
	localparam int IDX_W = $clog2(WIN);

	logic signed [COORD_WIDTH-1:0] x_win_q [WIN];
	logic signed [COORD_WIDTH-1:0] y_win_q [WIN];
	logic [WIN-1:0]                v_win_q;
	logic signed [SUM_W-1:0]       sum_x_q;
	logic signed [SUM_W-1:0]       sum_y_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [PS_W-1:0]               seen_q;
	logic                          busy_q;
	logic [K_W-1:0]                k_q;
	logic                          end_q;
	logic                          avg_q;

	logic                    accept;
	logic                    fin;
	logic                    at_half;
	logic [K_W-1:0]          top;
	logic signed [SUM_W-1:0] add_x, add_y, sub_x, sub_y;

	assign fin = !end_q || (k_q == '0);
	assign q_push = busy_q && !q_full;
	assign full = busy_q && !(q_push && fin);
	assign accept = push && !full;

	assign at_half = seen_q >= PS_W'(HALF_WINDOW);
	assign top = at_half ? K_W'(HALF_WINDOW) : K_W'(seen_q);

	assign add_x = point_valid ? SUM_W'(x_mm) : '0;
	assign add_y = point_valid ? SUM_W'(y_mm) : '0;
	assign sub_x = v_win_q[WIN-1] ? SUM_W'(x_win_q[WIN-1]) : '0;
	assign sub_y = v_win_q[WIN-1] ? SUM_W'(y_win_q[WIN-1]) : '0;

	assign q_ctl.avg = avg_q && (k_q == K_W'(HALF_WINDOW));
	assign q_ctl.edge_pt = !q_ctl.avg;
	assign q_ctl.last = end_q && (k_q == '0);
	assign q_x = x_win_q[IDX_W'(k_q)];
	assign q_y = y_win_q[IDX_W'(k_q)];
	assign q_sx = sum_x_q;
	assign q_sy = sum_y_q;
	assign q_cnt = cnt_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_win_q[0] <= x_mm;
			y_win_q[0] <= y_mm;
			for (int i = 1; i < WIN; i++) begin
				x_win_q[i] <= x_win_q[i-1];
				y_win_q[i] <= y_win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_win_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q <= '0;
			seen_q <= '0;
			busy_q <= 1'b0;
			k_q <= '0;
			end_q <= 1'b0;
			avg_q <= 1'b0;
		end else begin
			if (accept) begin
				v_win_q <= {v_win_q[WIN-2:0], point_valid};
				sum_x_q <= sum_x_q + add_x - sub_x;
				sum_y_q <= sum_y_q + add_y - sub_y;
				cnt_q <= cnt_q + CNT_W'(point_valid) - CNT_W'(v_win_q[WIN-1]);
				if (end_of_scan) begin
					seen_q <= '0;
				end else if (seen_q < PS_W'(2 * HALF_WINDOW)) begin
					seen_q <= seen_q + 1'b1;
				end
				busy_q <= end_of_scan || at_half;
				k_q <= end_of_scan ? top : K_W'(HALF_WINDOW);
				end_q <= end_of_scan;
				avg_q <= seen_q >= PS_W'(2 * HALF_WINDOW);
			end else if (q_push && fin) begin
				busy_q <= 1'b0;
			end else if (q_push) begin
				k_q <= k_q - 1'b1;
			end
		end
	end

endmodule

[rtl/mmas_fifo.sv]
// Short task queue between the front end and the back end.
module mmas_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              q_full,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              q_empty
);

	logic [DATA_W-1:0]         mem_q [mmas_pkg::Q_DEPTH];
	logic [mmas_pkg::Q_AW-1:0] wr_q;
	logic [mmas_pkg::Q_AW-1:0] rd_q;
	logic [mmas_pkg::Q_AW:0]   cnt_q;
	logic                      do_wr;
	logic                      do_rd;

	assign q_full = cnt_q == (mmas_pkg::Q_AW + 1)'(mmas_pkg::Q_DEPTH);
	assign q_empty = cnt_q == '0;
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/mmas_back.sv]
// Back end: serial mean divider and the result output register.
module mmas_back #(
	parameter int HALF_WINDOW = 4,
	parameter int COORD_WIDTH = 16,
	localparam int WIN = 2 * HALF_WINDOW + 1,
	localparam int CNT_W = $clog2(WIN + 1),
	localparam int SUM_W = COORD_WIDTH + $clog2(WIN)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  mmas_pkg::mmas_ctl_t           q_ctl,
	input  logic signed [COORD_WIDTH-1:0] q_x,
	input  logic signed [COORD_WIDTH-1:0] q_y,
	input  logic signed [SUM_W-1:0]       q_sx,
	input  logic signed [SUM_W-1:0]       q_sy,
	input  logic [CNT_W-1:0]              q_cnt,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_WIDTH-1:0] avg_x,
	output logic signed [COORD_WIDTH-1:0] avg_y,
	output logic                          all_invalid,
	output logic                          edge_point,
	output logic                          last_of_scan
);

	localparam int STEP_W = $clog2(SUM_W);

	mmas_pkg::mmas_bstate_t state_q, state_d;

	logic                          out_v_q;
	logic signed [COORD_WIDTH-1:0] avg_x_q, avg_y_q;
	logic                          inv_q, edge_q, last_q;
	logic [SUM_W-1:0]              quo_x_q, quo_y_q;
	logic [CNT_W-1:0]              rem_x_q, rem_y_q;
	logic [CNT_W-1:0]              div_q;
	logic                          neg_x_q, neg_y_q;
	logic [STEP_W-1:0]             step_q;

	logic             slot_free;
	logic             take_div;
	logic             load_raw;
	logic             load_zero;
	logic             load_div;
	logic [CNT_W:0]   sh_x, sh_y;
	logic             ge_x, ge_y;
	logic [SUM_W-1:0] res_x, res_y;

	assign slot_free = !out_v_q || pop;
	assign empty = !out_v_q;
	assign avg_x = avg_x_q;
	assign avg_y = avg_y_q;
	assign all_invalid = inv_q;
	assign edge_point = edge_q;
	assign last_of_scan = last_q;

	assign sh_x = {rem_x_q, quo_x_q[SUM_W-1]};
	assign sh_y = {rem_y_q, quo_y_q[SUM_W-1]};
	assign ge_x = sh_x >= {1'b0, div_q};
	assign ge_y = sh_y >= {1'b0, div_q};
	assign res_x = neg_x_q ? -quo_x_q : quo_x_q;
	assign res_y = neg_y_q ? -quo_y_q : quo_y_q;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		take_div = 1'b0;
		load_raw = 1'b0;
		load_zero = 1'b0;
		load_div = 1'b0;
		case (state_q)
			mmas_pkg::BK_IDLE: begin
				if (!q_empty) begin
					if (q_ctl.avg && (q_cnt != '0)) begin
						q_pop = 1'b1;
						take_div = 1'b1;
						state_d = mmas_pkg::BK_DIV;
					end else if (slot_free) begin
						q_pop = 1'b1;
						load_raw = !q_ctl.avg;
						load_zero = q_ctl.avg;
					end
				end
			end
			mmas_pkg::BK_DIV: begin
				if (step_q == '0) begin
					state_d = mmas_pkg::BK_DONE;
				end
			end
			mmas_pkg::BK_DONE: begin
				if (slot_free) begin
					load_div = 1'b1;
					state_d = mmas_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = mmas_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmas_pkg::BK_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_raw || load_zero || load_div) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_div) begin
			quo_x_q <= q_sx[SUM_W-1] ? -q_sx : q_sx;
			quo_y_q <= q_sy[SUM_W-1] ? -q_sy : q_sy;
			neg_x_q <= q_sx[SUM_W-1];
			neg_y_q <= q_sy[SUM_W-1];
			rem_x_q <= '0;
			rem_y_q <= '0;
			div_q <= q_cnt;
			step_q <= STEP_W'(SUM_W - 1);
			last_q <= last_q;
		end else if (state_q == mmas_pkg::BK_DIV) begin
			quo_x_q <= {quo_x_q[SUM_W-2:0], ge_x};
			quo_y_q <= {quo_y_q[SUM_W-2:0], ge_y};
			rem_x_q <= ge_x ? CNT_W'(sh_x - {1'b0, div_q}) : CNT_W'(sh_x);
			rem_y_q <= ge_y ? CNT_W'(sh_y - {1'b0, div_q}) : CNT_W'(sh_y);
			step_q <= step_q - 1'b1;
		end
		if (load_raw) begin
			avg_x_q <= q_x;
			avg_y_q <= q_y;
			inv_q <= 1'b0;
			edge_q <= 1'b1;
			last_q <= q_ctl.last;
		end else if (load_zero) begin
			avg_x_q <= '0;
			avg_y_q <= '0;
			inv_q <= 1'b1;
			edge_q <= 1'b0;
			last_q <= 1'b0;
		end else if (load_div) begin
			avg_x_q <= res_x[COORD_WIDTH-1:0];
			avg_y_q <= res_y[COORD_WIDTH-1:0];
			inv_q <= 1'b0;
			edge_q <= 1'b0;
			last_q <= 1'b0;
		end
	end

endmodule

[rtl/masked_moving_average_scan_top.sv]
// A point's result follows HALF_WINDOW points later; a raw result passes through the task queue and
// the output register, an averaged one also through the serial divider's BK_DIV and BK_DONE states.
// The front takes one point per cycle while the queue has room; an end-of-scan point blocks input
// until its tail results are queued, one per cycle while the queue has room.
// Raw results leave at one per cycle while popped; averaged ones at one per divider run.
// Reset clears the window valid bits, running sums, scan position, queue and output valid flag.
module masked_moving_average_scan_top #(
	parameter int HALF_WINDOW = 4,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] x_mm,
	input  logic signed [COORD_WIDTH-1:0] y_mm,
	input  logic                          point_valid,
	input  logic                          end_of_scan,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_WIDTH-1:0] avg_x,
	output logic signed [COORD_WIDTH-1:0] avg_y,
	output logic                          all_invalid,
	output logic                          edge_point,
	output logic                          last_of_scan
);

	localparam int WIN = 2 * HALF_WINDOW + 1;
	localparam int CNT_W = $clog2(WIN + 1);
	localparam int SUM_W = COORD_WIDTH + $clog2(WIN);
	localparam int ENT_W = $bits(mmas_pkg::mmas_ctl_t) + 2 * COORD_WIDTH + 2 * SUM_W + CNT_W;

	logic                          q_full, q_push, q_empty, q_pop;
	mmas_pkg::mmas_ctl_t           f_ctl, b_ctl;
	logic signed [COORD_WIDTH-1:0] f_x, f_y, b_x, b_y;
	logic signed [SUM_W-1:0]       f_sx, f_sy, b_sx, b_sy;
	logic [CNT_W-1:0]              f_cnt, b_cnt;
	logic [ENT_W-1:0]              q_wdata, q_rdata;

	assign q_wdata = {f_ctl, f_x, f_y, f_sx, f_sy, f_cnt};
	assign {b_ctl, b_x, b_y, b_sx, b_sy, b_cnt} = q_rdata;

	mmas_front #(
		.HALF_WINDOW(HALF_WINDOW),
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.x_mm(x_mm),
		.y_mm(y_mm),
		.point_valid(point_valid),
		.end_of_scan(end_of_scan),
		.q_full(q_full),
		.q_push(q_push),
		.q_ctl(f_ctl),
		.q_x(f_x),
		.q_y(f_y),
		.q_sx(f_sx),
		.q_sy(f_sy),
		.q_cnt(f_cnt)
	);

	mmas_fifo #(
		.DATA_W(ENT_W)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(q_push),
		.wr_data(q_wdata),
		.q_full(q_full),
		.rd_en(q_pop),
		.rd_data(q_rdata),
		.q_empty(q_empty)
	);

	mmas_back #(
		.HALF_WINDOW(HALF_WINDOW),
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_ctl(b_ctl),
		.q_x(b_x),
		.q_y(b_y),
		.q_sx(b_sx),
		.q_sy(b_sy),
		.q_cnt(b_cnt),
		.empty(empty),
		.pop(pop),
		.avg_x(avg_x),
		.avg_y(avg_y),
		.all_invalid(all_invalid),
		.edge_point(edge_point),
		.last_of_scan(last_of_scan)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("Task queued while the queue is full.");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && all_invalid) |-> (avg_x == '0 && avg_y == '0 && !edge_point))
		else $error("All-invalid result carries data or an edge mark.");

	a_last_is_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_of_scan) |-> edge_point)
		else $error("Final result of a scan is not a raw edge point.");

	a_avg_task_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && f_ctl.avg) |-> !f_ctl.last)
		else $error("Averaged task marked as the end of a scan.");

endmodule
